/* rtl/kbs_pkg.sv */
// ----------------------------------------------------------------------------
// kbs_pkg: shared types and arithmetic helpers for the kinematic body step
// Word layouts for both channels, register indexes and Q16.16 helpers.
// ----------------------------------------------------------------------------
package kbs_pkg;

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    CFG_TIME_STEP = 2'd0,
    CFG_GRAVITY   = 2'd1,
    CFG_FRICTION  = 2'd2
  } cfg_idx_t;

  localparam logic [16:0] TIME_STEP_RST = 17'd1092;

  // input word
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] height;
    logic signed [31:0] lift;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic        [30:0] thrust;
    logic        [30:0] speed_limit;
    logic        [3:0]  parts_present;
  } in_word_t;

  // result word
  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_height;
    logic signed [31:0] new_lift;
  } out_word_t;

  // per-stage working set carried down the pipeline
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] h;
    logic signed [31:0] lf;
    logic        [31:0] mx;     // direction magnitudes, normalized
    logic        [31:0] my;
    logic               sx;     // direction signs
    logic               sy;
    logic               tzero;  // zero direction: thrust along +x
    logic        [30:0] thr;
    logic        [30:0] lim;
    logic        [3:0]  parts;
    logic        [63:0] sq;     // root radicand remainder
    logic        [63:0] rt;     // root accumulator
    logic        [63:0] rmx;    // divider remainders
    logic        [63:0] rmy;
    logic        [31:0] den;    // divisor
    logic        [31:0] qx;     // quotients
    logic        [31:0] qy;
    logic               capped; // speed cap applies
  } kbs_work_t;

  localparam logic signed [35:0] SAT_MAX = 36'sd2147483647;
  localparam logic signed [35:0] SAT_MIN = -36'sd2147483648;

  // (a * dt) >> 16, rounded toward minus infinity
  function automatic logic signed [33:0] mul_dt(input logic signed [32:0] a,
                                                input logic [16:0] dt);
    logic signed [50:0] p;
    p = 51'(a) * 51'($signed({1'b0, dt}));
    return p[49:16];
  endfunction

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) r = 32'sh7fffffff;
    else if (v < SAT_MIN) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // magnitude of a signed 32-bit value
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

endpackage

/* rtl/kinematic_body_step.sv */
// ----------------------------------------------------------------------------
// kinematic_body_step: one explicit Euler step of a body in Q16.16
// Elevation and lift, normalized thrust, speed cap, friction and position.
// ----------------------------------------------------------------------------
//  channel | ports                              | moves
//  --------+------------------------------------+------------------------------
//  in      | in_valid, in_stall, in_data        | one body state word
//  out     | out_valid, out_stall, out_data     | one updated body word
//  cfg     | cfg_we, cfg_index, cfg_wdata       | register write, no wait
//
//  One word enters per cycle while in_stall is low, through 75 register
//  stages. The depth is set by two 64-bit square root units and two
//  32-bit quotient dividers, two steps a stage. Synchronous active-low
//  reset clears the valid bits and loads the configuration registers,
//  not the pipeline data. A held result word freezes the whole pipeline
//  and raises in_stall; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module kinematic_body_step
  import kbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [30:0] cfg_wdata
);

  // stage map
  localparam int ST_A   = 0;
  localparam int ST_B   = 1;
  localparam int ST_C   = 2;
  localparam int ST_SQ1 = 3;
  localparam int N_SQ   = 16;
  localparam int ST_D   = ST_SQ1 + N_SQ;
  localparam int ST_DV1 = ST_D + 1;
  localparam int N_DV   = 16;
  localparam int ST_E   = ST_DV1 + N_DV;
  localparam int ST_F   = ST_E + 1;
  localparam int ST_G   = ST_F + 1;
  localparam int ST_SQ2 = ST_G + 1;
  localparam int ST_H   = ST_SQ2 + N_SQ;
  localparam int ST_DV2 = ST_H + 1;
  localparam int ST_I   = ST_DV2 + N_DV;
  localparam int ST_J   = ST_I + 1;
  localparam int ST_K   = ST_J + 1;
  localparam int NST    = ST_K + 1;

  logic [16:0] dt_r;
  logic [30:0] grav_r;
  logic [30:0] fric_r;

  kbs_work_t st_r   [NST];
  kbs_work_t st_nxt [NST];
  logic      vld_r  [NST];
  logic      adv;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r   <= TIME_STEP_RST;
      grav_r <= '0;
      fric_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TIME_STEP: dt_r   <= cfg_wdata[16:0];
        CFG_GRAVITY:   grav_r <= cfg_wdata;
        CFG_FRICTION:  fric_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless the last word is held
  assign adv      = !vld_r[NST-1] || !out_stall;
  assign in_stall = !adv;

  for (genvar k = 0; k < NST; k++) begin : g_stage
    if (k == ST_A) begin : g_a
      // elevation, direction magnitudes, coarse normalize
      always_comb begin
        kbs_work_t t;
        logic signed [31:0] h2;
        logic signed [31:0] lf2;
        logic [31:0] m;
        t        = '0;
        t.px     = in_data.pos_x;
        t.py     = in_data.pos_y;
        t.vx     = in_data.vel_x;
        t.vy     = in_data.vel_y;
        t.h      = in_data.height;
        t.lf     = in_data.lift;
        t.thr    = in_data.thrust;
        t.lim    = in_data.speed_limit;
        t.parts  = in_data.parts_present;
        h2  = sat32(36'(in_data.height) + 36'(mul_dt(33'(in_data.lift), dt_r)));
        lf2 = sat32(36'(in_data.lift) - 36'(mul_dt($signed({2'b0, grav_r}), dt_r)));
        if (t.parts[0] && t.parts[1]) begin
          if (h2 > 32'sd0) begin
            t.h  = h2;
            t.lf = lf2;
          end else begin
            t.h  = '0;
            t.lf = '0;
          end
        end
        t.sx = in_data.dir_x[31];
        t.sy = in_data.dir_y[31];
        t.mx = mag32(in_data.dir_x);
        t.my = mag32(in_data.dir_y);
        t.tzero = (t.mx == '0) && (t.my == '0);
        m = (t.my > t.mx) ? t.my : t.mx;
        if (m < 32'd32768) begin
          m    = m << 16;
          t.mx = t.mx << 16;
          t.my = t.my << 16;
        end
        if (m < 32'd8388608) begin
          t.mx = t.mx << 8;
          t.my = t.my << 8;
        end
        st_nxt[k] = t;
      end
    end else if (k == ST_B) begin : g_b
      // fine normalize
      always_comb begin
        kbs_work_t t;
        logic [31:0] m;
        t = st_r[k-1];
        m = (t.my > t.mx) ? t.my : t.mx;
        if (m < 32'd134217728) begin
          m    = m << 4;
          t.mx = t.mx << 4;
          t.my = t.my << 4;
        end
        if (m < 32'd536870912) begin
          m    = m << 2;
          t.mx = t.mx << 2;
          t.my = t.my << 2;
        end
        if (m < 32'd1073741824) begin
          t.mx = t.mx << 1;
          t.my = t.my << 1;
        end
        st_nxt[k] = t;
      end
    end else if (k == ST_C) begin : g_c
      // squared length of the direction
      always_comb begin
        kbs_work_t t;
        t    = st_r[k-1];
        t.sq = ({32'b0, t.mx} * {32'b0, t.mx}) + ({32'b0, t.my} * {32'b0, t.my});
        t.rt = '0;
        st_nxt[k] = t;
      end
    end else if ((k >= ST_SQ1 && k < ST_SQ1 + N_SQ) ||
                 (k >= ST_SQ2 && k < ST_SQ2 + N_SQ)) begin : g_sqrt
      // two digit steps of the bitwise square root
      localparam int SI = (k >= ST_SQ2) ? (k - ST_SQ2) : (k - ST_SQ1);
      always_comb begin
        kbs_work_t t;
        logic [63:0] bb;
        t = st_r[k-1];
        for (int it = 0; it < 2; it++) begin
          bb = 64'd1 << (62 - 2 * (2 * SI + it));
          if (t.sq >= t.rt + bb) begin
            t.sq = t.sq - (t.rt + bb);
            t.rt = (t.rt >> 1) + bb;
          end else begin
            t.rt = t.rt >> 1;
          end
        end
        st_nxt[k] = t;
      end
    end else if (k == ST_D) begin : g_d
      // thrust dividends
      always_comb begin
        kbs_work_t t;
        t     = st_r[k-1];
        t.den = t.rt[31:0];
        t.rmx = {32'b0, t.mx} * {33'b0, t.thr};
        t.rmy = {32'b0, t.my} * {33'b0, t.thr};
        t.qx  = '0;
        t.qy  = '0;
        st_nxt[k] = t;
      end
    end else if ((k >= ST_DV1 && k < ST_DV1 + N_DV) ||
                 (k >= ST_DV2 && k < ST_DV2 + N_DV)) begin : g_div
      // two quotient bits per stage, both axes
      localparam int DI = (k >= ST_DV2) ? (k - ST_DV2) : (k - ST_DV1);
      always_comb begin
        kbs_work_t t;
        logic [63:0] dsh;
        logic [4:0] bt;
        t = st_r[k-1];
        for (int it = 0; it < 2; it++) begin
          bt  = 5'(31 - (2 * DI + it));
          dsh = {32'b0, t.den} << bt;
          if (t.rmx >= dsh) begin
            t.rmx    = t.rmx - dsh;
            t.qx[bt] = 1'b1;
          end
          if (t.rmy >= dsh) begin
            t.rmy    = t.rmy - dsh;
            t.qy[bt] = 1'b1;
          end
        end
        st_nxt[k] = t;
      end
    end else if (k == ST_E) begin : g_e
      // apply thrust, y negated
      always_comb begin
        kbs_work_t t;
        logic signed [32:0] tx;
        logic signed [32:0] ty;
        t  = st_r[k-1];
        tx = $signed({2'b0, t.qx[30:0]});
        ty = $signed({2'b0, t.qy[30:0]});
        if (t.sx) tx = -tx;
        if (t.sy) ty = -ty;
        if (t.tzero) begin
          tx = $signed({2'b0, t.thr});
          ty = '0;
        end
        if (t.parts[0] && t.parts[2]) begin
          t.vx = sat32(36'(t.vx) + 36'(mul_dt(tx, dt_r)));
          t.vy = sat32(36'(t.vy) - 36'(mul_dt(ty, dt_r)));
        end
        st_nxt[k] = t;
      end
    end else if (k == ST_F) begin : g_f
      // squared speed and squared limit
      always_comb begin
        kbs_work_t t;
        logic [31:0] ux;
        logic [31:0] uy;
        t     = st_r[k-1];
        ux    = mag32(t.vx);
        uy    = mag32(t.vy);
        t.sq  = ({32'b0, ux} * {32'b0, ux}) + ({32'b0, uy} * {32'b0, uy});
        t.rmx = {33'b0, t.lim} * {33'b0, t.lim};
        t.rt  = '0;
        st_nxt[k] = t;
      end
    end else if (k == ST_G) begin : g_g
      // cap decision
      always_comb begin
        kbs_work_t t;
        t        = st_r[k-1];
        t.capped = t.parts[0] && t.parts[2] && (t.sq > t.rmx);
        st_nxt[k] = t;
      end
    end else if (k == ST_H) begin : g_h
      // cap dividends
      always_comb begin
        kbs_work_t t;
        t     = st_r[k-1];
        t.den = t.rt[31:0];
        t.rmx = {32'b0, mag32(t.vx)} * {33'b0, t.lim};
        t.rmy = {32'b0, mag32(t.vy)} * {33'b0, t.lim};
        t.qx  = '0;
        t.qy  = '0;
        st_nxt[k] = t;
      end
    end else if (k == ST_I) begin : g_i
      // rescaled velocity
      always_comb begin
        kbs_work_t t;
        t = st_r[k-1];
        if (t.capped) begin
          t.vx = t.vx[31] ? -$signed(t.qx) : $signed(t.qx);
          t.vy = t.vy[31] ? -$signed(t.qy) : $signed(t.qy);
        end
        st_nxt[k] = t;
      end
    end else if (k == ST_J) begin : g_j
      // friction toward zero, never across
      always_comb begin
        kbs_work_t t;
        logic signed [33:0] d;
        logic signed [34:0] nx;
        logic signed [34:0] ny;
        t  = st_r[k-1];
        d  = mul_dt($signed({2'b0, fric_r}), dt_r);
        nx = 35'(t.vx);
        ny = 35'(t.vy);
        if (t.vx > 32'sd0) begin
          nx = 35'(t.vx) - 35'(d);
          if (nx < 35'sd0) nx = '0;
        end else if (t.vx < 32'sd0) begin
          nx = 35'(t.vx) + 35'(d);
          if (nx > 35'sd0) nx = '0;
        end
        if (t.vy > 32'sd0) begin
          ny = 35'(t.vy) - 35'(d);
          if (ny < 35'sd0) ny = '0;
        end else if (t.vy < 32'sd0) begin
          ny = 35'(t.vy) + 35'(d);
          if (ny > 35'sd0) ny = '0;
        end
        if (t.parts[0] && t.parts[3]) begin
          t.vx = nx[31:0];
          t.vy = ny[31:0];
        end
        st_nxt[k] = t;
      end
    end else begin : g_k
      // position update, output register
      always_comb begin
        kbs_work_t t;
        t = st_r[k-1];
        if (t.parts[0]) begin
          t.px = sat32(36'(t.px) + 36'(mul_dt(33'(t.vx), dt_r)));
          t.py = sat32(36'(t.py) + 36'(mul_dt(33'(t.vy), dt_r)));
        end
        st_nxt[k] = t;
      end
    end
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (adv) begin
      st_r <= st_nxt;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < NST; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // result word
  assign out_valid           = vld_r[NST-1];
  assign out_data.new_pos_x  = st_r[NST-1].px;
  assign out_data.new_pos_y  = st_r[NST-1].py;
  assign out_data.new_vel_x  = st_r[NST-1].vx;
  assign out_data.new_vel_y  = st_r[NST-1].vy;
  assign out_data.new_height = st_r[NST-1].h;
  assign out_data.new_lift   = st_r[NST-1].lf;

endmodule

/* tb/kbs_checker.sv */
// ----------------------------------------------------------------------------
// kbs_checker: result checker for the kinematic body step
// Mirrors the register writes, predicts one result word for every accepted
// input word, and compares each accepted result word with the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module kbs_checker
  import kbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  in_word_t   in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  out_word_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [30:0] cfg_wdata,
  output int         fail_count,
  output int         words_due
);

  longint unsigned dt_q;
  longint unsigned grav_q;
  longint unsigned fric_q;
  out_word_t       body_due_q[$];

  initial begin
    fail_count = 0;
    words_due  = 0;
  end

  // (a * dt) >> 16, floor
  function automatic longint scale_dt(longint a);
    longint p;
    p = a * longint'(dt_q);
    return p >>> 16;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // num * k / den, truncated toward zero
  function automatic longint ratio_scale(longint num, longint unsigned k,
                                         longint unsigned den);
    longint unsigned mag, q;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q = (mag * k) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // one Euler step of a body
  function automatic out_word_t step_body(in_word_t w);
    longint px, py, vx, vy, h, lf, ax, ay, tx, ty, d;
    longint unsigned thr, lim, m, dm, s, sm;
    out_word_t r;
    px = longint'(w.pos_x);  py = longint'(w.pos_y);
    vx = longint'(w.vel_x);  vy = longint'(w.vel_y);
    h  = longint'(w.height); lf = longint'(w.lift);
    thr = 64'(w.thrust);
    lim = 64'(w.speed_limit);
    if (w.parts_present[0]) begin
      // elevation and lift, landing clears both
      if (w.parts_present[1]) begin
        h = clamp32(h + scale_dt(lf));
        if (h > 0) begin
          lf = clamp32(lf - scale_dt(longint'(grav_q)));
        end else begin
          h  = 0;
          lf = 0;
        end
      end
      // thrust along the normalized direction, then the speed cap
      if (w.parts_present[2]) begin
        ax = longint'(w.dir_x);
        ay = longint'(w.dir_y);
        m  = magnitude(ax);
        if (magnitude(ay) > m) m = magnitude(ay);
        if (m == 0) begin
          tx = longint'(thr);
          ty = 0;
        end else begin
          while (m < 64'd1073741824) begin
            m  = m << 1;
            ax = ax * 2;
            ay = ay * 2;
          end
          dm = floor_root(longint'(ax * ax) + longint'(ay * ay));
          tx = ratio_scale(ax, thr, dm);
          ty = ratio_scale(ay, thr, dm);
        end
        vx = clamp32(vx + scale_dt(tx));
        vy = clamp32(vy - scale_dt(ty));
        s  = longint'(vx * vx) + longint'(vy * vy);
        if (s > lim * lim) begin
          sm = floor_root(s);
          vx = ratio_scale(vx, lim, sm);
          vy = ratio_scale(vy, lim, sm);
        end
      end
      // friction toward zero, never across it
      if (w.parts_present[3]) begin
        d = scale_dt(longint'(fric_q));
        if (vx > 0) begin
          vx = vx - d;
          if (vx < 0) vx = 0;
        end else if (vx < 0) begin
          vx = vx + d;
          if (vx > 0) vx = 0;
        end
        if (vy > 0) begin
          vy = vy - d;
          if (vy < 0) vy = 0;
        end else if (vy < 0) begin
          vy = vy + d;
          if (vy > 0) vy = 0;
        end
      end
      px = clamp32(px + scale_dt(vx));
      py = clamp32(py + scale_dt(vy));
    end
    r.new_pos_x  = px[31:0];
    r.new_pos_y  = py[31:0];
    r.new_vel_x  = vx[31:0];
    r.new_vel_y  = vy[31:0];
    r.new_height = h[31:0];
    r.new_lift   = lf[31:0];
    return r;
  endfunction

  task automatic match_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  // watch all three ports
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      dt_q   = 64'(TIME_STEP_RST);
      grav_q = 0;
      fric_q = 0;
      body_due_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_TIME_STEP) dt_q = 64'(cfg_wdata[16:0]);
        else if (cfg_index == CFG_GRAVITY) grav_q = 64'(cfg_wdata);
        else if (cfg_index == CFG_FRICTION) fric_q = 64'(cfg_wdata);
      end
      if (in_valid && !in_stall) body_due_q.push_back(step_body(in_data));
      if (out_valid && !out_stall) begin
        if (body_due_q.size() == 0) begin
          $error("result word with no input word pending");
          fail_count++;
        end else begin
          want = body_due_q.pop_front();
          match_field("new_pos_x", want.new_pos_x, out_data.new_pos_x);
          match_field("new_pos_y", want.new_pos_y, out_data.new_pos_y);
          match_field("new_vel_x", want.new_vel_x, out_data.new_vel_x);
          match_field("new_vel_y", want.new_vel_y, out_data.new_vel_y);
          match_field("new_height", want.new_height, out_data.new_height);
          match_field("new_lift", want.new_lift, out_data.new_lift);
        end
      end
    end
    words_due = body_due_q.size();
  end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for the kinematic body step
// Drives directed and random body words under several register settings and
// random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import kbs_pkg::*;

  localparam int DRAIN_CYCLES = 90;
  localparam int QUIET_LIMIT  = 6000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_word_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_data;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_TIME_STEP;
  logic [30:0] cfg_wdata = '0;
  int         fail_count;
  int         words_due;
  int         send_idle = 0;
  int         recv_idle = 0;
  int         hold_req = 0;
  int         hold_left = 0;
  int         quiet = 0;

  always #6 clk = ~clk;

  kinematic_body_step u_top (.*);

  kbs_checker u_chk (.*);

  // receiver: random stall plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_req  = 0;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write enable stays high across back-to-back writes
  task automatic write_reg(cfg_idx_t idx, logic [30:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  // mix of full range, small, medium and edge values
  function automatic logic [31:0] pick32();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2 * 65536 * 16)) - 65536 * 16);
      2: return 32'($signed($urandom_range(1 << 25)) - (1 << 24));
      3: case ($urandom_range(4))
           0: return 32'h7fffffff;
           1: return 32'h80000000;
           2: return 32'h0;
           3: return 32'h1;
           default: return 32'hffffffff;
         endcase
      default: return 32'($signed($urandom_range(1 << 21)) - (1 << 20));
    endcase
  endfunction

  function automatic in_word_t random_body();
    in_word_t w;
    logic [31:0] t;
    w.pos_x  = pick32();
    w.pos_y  = pick32();
    w.vel_x  = pick32();
    w.vel_y  = pick32();
    w.height = pick32();
    w.lift   = pick32();
    w.dir_x  = ($urandom_range(7) == 0) ? 32'h0 : pick32();
    w.dir_y  = ($urandom_range(7) == 0) ? 32'h0 : pick32();
    t = pick32();
    w.thrust = t[30:0];
    t = pick32();
    w.speed_limit = ($urandom_range(3) == 0) ? 31'h7fffffff : t[30:0];
    w.parts_present = 4'($urandom_range(15));
    if ($urandom_range(4) != 0) w.parts_present[0] = 1'b1;
    return w;
  endfunction

  // edge cases on a quiet base body
  function automatic in_word_t directed_body(int k);
    in_word_t w;
    w = '0;
    w.vel_x = 32'sh0002_0000;
    w.vel_y = -32'sh0001_8000;
    w.height = 32'sh0001_0000;
    w.lift = 32'sh0000_4000;
    w.dir_x = 32'sh0000_3000;
    w.dir_y = -32'sh0000_1000;
    w.thrust = 31'h0004_0000;
    w.speed_limit = 31'h7fffffff;
    w.parts_present = 4'hf;
    case (k)
      0: w.parts_present = 4'h0;
      1: w.parts_present = 4'h1;
      2: w.parts_present = 4'h3;
      3: w.parts_present = 4'h5;
      4: w.parts_present = 4'h9;
      5: w.parts_present = 4'he;
      6: begin w.dir_x = 0; w.dir_y = 0; end
      7: begin w.height = 32'sh0000_0010; w.lift = -32'sh0100_0000; end
      8: begin w.height = 0; w.lift = 0; end
      9: begin w.pos_x = 32'sh7fffffff; w.pos_y = 32'sh80000000;
           w.vel_x = 32'sh7fffffff; w.vel_y = 32'sh80000000; end
      10: begin w.dir_x = 32'sh80000000; w.dir_y = 32'sh80000000;
            w.thrust = 31'h7fffffff; end
      11: begin w.dir_x = 32'sh7fffffff; w.dir_y = 32'sh1; end
      12: begin w.dir_x = 0; w.dir_y = -32'sh1; end
      13: w.speed_limit = 31'h0001_0000;
      14: w.speed_limit = 0;
      15: begin w.vel_x = 32'sh10; w.vel_y = -32'sh10; w.parts_present = 4'h9; end
      16: begin w.height = 32'sh7fffffff; w.lift = 32'sh7fffffff; end
      17: begin w.height = 32'sh80000000; w.lift = 32'sh80000000; end
      18: begin w.vel_x = 0; w.vel_y = 0; w.parts_present = 4'h9; end
      default: begin
        w.pos_x = 32'sh80000000; w.vel_x = 32'sh80000000;
        w.speed_limit = 31'h7fffffff; w.thrust = 31'h7fffffff;
        w.dir_x = -32'sh1; w.dir_y = 0;
      end
    endcase
    return w;
  endfunction

  // register sets per phase, extremes included
  task automatic load_regs(int phase);
    case (phase)
      0: begin
        write_reg(CFG_TIME_STEP, 31'd1092);
        write_reg(CFG_GRAVITY, 31'h0003_0000);
        write_reg(CFG_FRICTION, 31'h0000_8000);
      end
      1: begin
        write_reg(CFG_TIME_STEP, 31'd65536);
        write_reg(CFG_GRAVITY, 31'h7fffffff);
        write_reg(CFG_FRICTION, 31'h7fffffff);
      end
      2: begin
        write_reg(CFG_TIME_STEP, 31'd0);
        write_reg(CFG_GRAVITY, 31'd0);
        write_reg(CFG_FRICTION, 31'd0);
      end
      3: begin
        write_reg(CFG_TIME_STEP, 31'($urandom_range(65536)));
        write_reg(CFG_GRAVITY, 31'($urandom));
        write_reg(CFG_FRICTION, 31'($urandom_range(1 << 20)));
      end
      4: begin
        write_reg(CFG_TIME_STEP, 31'd1);
        write_reg(CFG_GRAVITY, 31'd1);
        write_reg(CFG_FRICTION, 31'd1);
      end
      default: begin
        write_reg(CFG_TIME_STEP, 31'd32768);
        write_reg(CFG_GRAVITY, 31'($urandom_range(1 << 22)));
        write_reg(CFG_FRICTION, 31'($urandom));
      end
    endcase
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words at reset register values, then four of them again at phase 0 values
    for (int k = 0; k < 20; k++) send_word(directed_body(k));
    drain();
    load_regs(0);
    for (int k = 0; k < 4; k++) send_word(directed_body(6 + k));
    drain();

    // random phases: receiver-heavy idle, sender-heavy idle, then none
    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin send_idle = 33; recv_idle = 86; end
      else if (ph < 4) begin send_idle = 86; recv_idle = 33; end
      else begin send_idle = 0; recv_idle = 0; end
      load_regs(ph);
      for (int i = 0; i < 80; i++) begin
        if (ph == 4 && i == 10) hold_req = 1;
        if (ph == 2 && i == 40) drain();
        send_word(random_body());
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* kinematic_body_step.f */
rtl/kbs_pkg.sv
rtl/kinematic_body_step.sv
tb/kbs_checker.sv
tb/tb_top.sv
